// ===== rtl/rmpd_pkg.sv =====
// ----------------------------------------------------------------------------
// rmpd_pkg
// Shared types, constants and helpers for the run list mapping pair decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rmpd_pkg;

	// Default cluster number width and the widest field that is decoded
	localparam int CLUSTER_BITS    = 40;
	localparam int MAX_FIELD_BYTES = 8;

	// Configuration register widths and reset values
	localparam int BPS_W     = 13;
	localparam int SPC_W     = 8;
	localparam int BPC_W     = BPS_W + SPC_W;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 1;
	localparam logic [BPS_W-1:0] BPS_RST = 13'd512;
	localparam logic [SPC_W-1:0] SPC_RST = 8'd8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_SECTOR    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SECTORS_PER_CLUSTER = 1'b1;

	// Result field widths
	localparam int SC_W    = 40;
	localparam int LEN_W   = 32;
	localparam int ADDR_W  = 59;
	localparam int CNT_W   = 32;
	localparam int ST_W    = 3;
	localparam int ACC_W   = 64;
	localparam int OUT_DATA_W = 168;
	localparam int OUT_USER_W = 4;

	// Result status codes
	typedef enum logic [ST_W-1:0] {
		ST_OK         = 3'd0,
		ST_NEG_LEN    = 3'd1,
		ST_FIELD_WIDE = 3'd2,
		ST_RANGE      = 3'd3,
		ST_CNT_OVF    = 3'd4
	} status_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic       hdr_load;   // nonzero header: clear accumulators
		logic       hdr_end;    // zero header: queue an end-of-list result
		logic       clear_run;  // new list: running cluster back to zero
		logic       acc_len;    // merge byte into length accumulator
		logic       acc_off;    // merge byte into offset accumulator
		logic [2:0] byte_sel;   // byte lane of the accumulator
		logic       calc;       // run check and cluster update
		logic       mul;        // scaling products
		logic       emit;       // load the output register
		logic [3:0] len_size;
		logic [3:0] off_size;
	} rmpd_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic out_free;         // output register can take a result
	} rmpd_stat_t;

	// Sign-extend a little-endian field of n bytes; zero bytes reads as 0
	function automatic logic [ACC_W-1:0] sext_field(input logic [ACC_W-1:0] acc,
		input logic [3:0] n);
		logic [ACC_W-1:0] r;
		logic             sgn;
		r   = '0;
		sgn = 1'b0;
		case (n)
			4'd1: sgn = acc[7];
			4'd2: sgn = acc[15];
			4'd3: sgn = acc[23];
			4'd4: sgn = acc[31];
			4'd5: sgn = acc[39];
			4'd6: sgn = acc[47];
			4'd7: sgn = acc[55];
			default: sgn = 1'b0;
		endcase
		if (n == 4'd0) begin
			r = '0;
		end else if (n >= 4'd8) begin
			r = acc;
		end else begin
			for (int k = 0; k < 8; k++) begin
				r[k*8 +: 8] = (4'(k) < n) ? acc[k*8 +: 8] : {8{sgn}};
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/rmpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmpd_ctrl
// Parse controller: tracks header, length and offset bytes and sequences the
// run completion steps of the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module rmpd_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [7:0]          run_byte,
	input  wire logic                list_start,
	input  wire rmpd_pkg::rmpd_stat_t stat,
	output rmpd_pkg::rmpd_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_HDR,
		S_LEN,
		S_OFF,
		S_CALC,
		S_MUL,
		S_EMIT
	} state_t;

	state_t     state_q;
	logic [3:0] len_size_q;
	logic [3:0] off_size_q;
	logic [3:0] idx_q;
	logic [3:0] idx_nxt;
	logic       accept;
	logic       is_hdr;

	assign s_tready = (state_q == S_HDR) || (state_q == S_LEN) || (state_q == S_OFF);
	assign accept   = s_tvalid && s_tready;
	assign idx_nxt  = idx_q + 4'd1;
	// list_start forces header handling in any parse state
	assign is_hdr   = list_start || (state_q == S_HDR);

	// Command decode
	always_comb begin
		cmd           = '0;
		cmd.len_size  = len_size_q;
		cmd.off_size  = off_size_q;
		cmd.byte_sel  = idx_q[2:0];
		if (accept) begin
			if (is_hdr) begin
				cmd.clear_run = list_start;
				cmd.hdr_end   = (run_byte == 8'd0);
				cmd.hdr_load  = (run_byte != 8'd0);
			end else if (state_q == S_LEN) begin
				// bytes past the eighth are dropped
				cmd.acc_len = !idx_q[3];
			end else begin
				cmd.acc_off = !idx_q[3];
			end
		end
		cmd.calc = (state_q == S_CALC);
		cmd.mul  = (state_q == S_MUL);
		cmd.emit = (state_q == S_EMIT) && stat.out_free;
	end

	// State and field size tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_HDR;
			len_size_q <= 4'd0;
			off_size_q <= 4'd0;
			idx_q      <= 4'd0;
		end else begin
			case (state_q)
				S_HDR, S_LEN, S_OFF: begin
					if (accept) begin
						if (is_hdr) begin
							idx_q <= 4'd0;
							if (run_byte == 8'd0) begin
								state_q <= S_EMIT;
							end else begin
								len_size_q <= run_byte[3:0];
								off_size_q <= run_byte[7:4];
								state_q    <= (run_byte[3:0] != 4'd0) ? S_LEN : S_OFF;
							end
						end else if (state_q == S_LEN) begin
							if (idx_nxt >= len_size_q) begin
								idx_q   <= 4'd0;
								state_q <= (off_size_q != 4'd0) ? S_OFF : S_CALC;
							end else begin
								idx_q <= idx_nxt;
							end
						end else begin
							if (idx_nxt >= off_size_q) begin
								idx_q   <= 4'd0;
								state_q <= S_CALC;
							end else begin
								idx_q <= idx_nxt;
							end
						end
					end
				end
				S_CALC: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (stat.out_free) begin
						state_q <= S_HDR;
					end
				end
				default: begin
					state_q <= S_HDR;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rmpd_dpath.sv =====
// ----------------------------------------------------------------------------
// rmpd_dpath
// Datapath: field accumulators, running cluster, range checks, scaling
// multipliers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rmpd_dpath #(
	parameter int CLUSTER_BITS = rmpd_pkg::CLUSTER_BITS
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [rmpd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [rmpd_pkg::CFG_W-1:0]           cfg_wdata,
	input  wire logic [7:0]                           run_byte,
	input  wire rmpd_pkg::rmpd_cmd_t                  cmd,
	output rmpd_pkg::rmpd_stat_t                      stat,
	input  wire logic                                 m_tready,
	output logic                                      out_valid,
	output logic [rmpd_pkg::SC_W-1:0]                 start_cluster,
	output logic [rmpd_pkg::LEN_W-1:0]                length_clusters,
	output logic [rmpd_pkg::ADDR_W-1:0]               byte_address,
	output logic [rmpd_pkg::CNT_W-1:0]                byte_count,
	output logic                                      sparse_run,
	output logic                                      list_end,
	output logic [rmpd_pkg::ST_W-1:0]                 status
);

	localparam int ACC_W   = rmpd_pkg::ACC_W;
	localparam int BPC_W   = rmpd_pkg::BPC_W;
	localparam int LEN_W   = rmpd_pkg::LEN_W;
	localparam int SUM_W   = ACC_W + 2;
	localparam int APROD_W = CLUSTER_BITS + BPC_W;
	localparam int CPROD_W = LEN_W + BPC_W;

	// Configuration and derived bytes per cluster
	logic [rmpd_pkg::BPS_W-1:0] bps_q;
	logic [rmpd_pkg::SPC_W-1:0] spc_q;
	logic [BPC_W-1:0]           bpc_q;

	// Parse state
	logic [ACC_W-1:0]        len_acc_q;
	logic [ACC_W-1:0]        off_acc_q;
	logic [CLUSTER_BITS-1:0] run_q;
	logic                    end_q;

	// Run check results
	logic [CLUSTER_BITS-1:0] next_q;
	logic [LEN_W-1:0]        len_q;
	rmpd_pkg::status_t       st_q;
	logic                    sparse_q;

	// Scaling products
	logic [APROD_W-1:0]      addr_prod_q;
	logic [CPROD_W-1:0]      cnt_prod_q;

	// Output register
	logic                          out_valid_q;
	logic [rmpd_pkg::SC_W-1:0]     sc_o_q;
	logic [LEN_W-1:0]              len_o_q;
	logic [rmpd_pkg::ADDR_W-1:0]   addr_o_q;
	logic [rmpd_pkg::CNT_W-1:0]    cnt_o_q;
	logic                          sparse_o_q;
	logic                          end_o_q;
	logic [rmpd_pkg::ST_W-1:0]     st_o_q;

	// Combinational terms
	logic [ACC_W-1:0]  len_ext;
	logic [ACC_W-1:0]  off_ext;
	logic [SUM_W-1:0]  sum;
	logic              range_bad;
	logic              field_wide;
	rmpd_pkg::status_t st_calc;
	logic [LEN_W-1:0]  len_sat;
	logic              cnt_over;
	logic              run_err;

	// Run check: sign-extend fields, add offset to running cluster
	always_comb begin
		len_ext    = rmpd_pkg::sext_field(len_acc_q, cmd.len_size);
		off_ext    = rmpd_pkg::sext_field(off_acc_q, cmd.off_size);
		sum        = SUM_W'(run_q) + {{2{off_ext[ACC_W-1]}}, off_ext};
		range_bad  = |sum[SUM_W-1:CLUSTER_BITS];
		field_wide = (cmd.len_size > 4'(rmpd_pkg::MAX_FIELD_BYTES)) ||
		             (cmd.off_size > 4'(rmpd_pkg::MAX_FIELD_BYTES));
		len_sat    = (|len_ext[ACC_W-1:LEN_W]) ? '1 : len_ext[LEN_W-1:0];
		if (field_wide) begin
			st_calc = rmpd_pkg::ST_FIELD_WIDE;
		end else if (len_ext[ACC_W-1]) begin
			st_calc = rmpd_pkg::ST_NEG_LEN;
		end else if (range_bad) begin
			st_calc = rmpd_pkg::ST_RANGE;
		end else if (|len_ext[ACC_W-2:LEN_W]) begin
			st_calc = rmpd_pkg::ST_CNT_OVF;
		end else begin
			st_calc = rmpd_pkg::ST_OK;
		end
	end

	// Config, accumulators, running cluster
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bps_q     <= rmpd_pkg::BPS_RST;
			spc_q     <= rmpd_pkg::SPC_RST;
			len_acc_q <= '0;
			off_acc_q <= '0;
			run_q     <= '0;
			end_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					rmpd_pkg::REG_BYTES_PER_SECTOR:    bps_q <= cfg_wdata;
					rmpd_pkg::REG_SECTORS_PER_CLUSTER: spc_q <= cfg_wdata[rmpd_pkg::SPC_W-1:0];
					default: ;
				endcase
			end
			if (cmd.hdr_load) begin
				len_acc_q <= '0;
				off_acc_q <= '0;
			end else if (cmd.acc_len) begin
				len_acc_q[cmd.byte_sel*8 +: 8] <= len_acc_q[cmd.byte_sel*8 +: 8] | run_byte;
			end else if (cmd.acc_off) begin
				off_acc_q[cmd.byte_sel*8 +: 8] <= off_acc_q[cmd.byte_sel*8 +: 8] | run_byte;
			end
			if (cmd.clear_run) begin
				run_q <= '0;
			end else if (cmd.calc && (st_calc == rmpd_pkg::ST_OK ||
			                          st_calc == rmpd_pkg::ST_CNT_OVF)) begin
				run_q <= sum[CLUSTER_BITS-1:0];
			end
			if (cmd.hdr_end) begin
				end_q <= 1'b1;
			end else if (cmd.calc) begin
				end_q <= 1'b0;
			end
		end
	end

	// Bytes per cluster, check results and scaling products
	always_ff @(posedge clk) begin
		bpc_q <= BPC_W'(bps_q) * BPC_W'(spc_q);
		if (cmd.calc) begin
			next_q   <= sum[CLUSTER_BITS-1:0];
			len_q    <= len_sat;
			st_q     <= st_calc;
			sparse_q <= (cmd.off_size == 4'd0);
		end
		if (cmd.mul) begin
			addr_prod_q <= APROD_W'(next_q) * APROD_W'(bpc_q);
			cnt_prod_q  <= CPROD_W'(len_q) * CPROD_W'(bpc_q);
		end
	end

	assign cnt_over = |cnt_prod_q[CPROD_W-1:rmpd_pkg::CNT_W];
	assign run_err  = (st_q == rmpd_pkg::ST_NEG_LEN) || (st_q == rmpd_pkg::ST_FIELD_WIDE) ||
	                  (st_q == rmpd_pkg::ST_RANGE);

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (end_q) begin
				sc_o_q     <= '0;
				len_o_q    <= '0;
				addr_o_q   <= '0;
				cnt_o_q    <= '0;
				sparse_o_q <= 1'b0;
				end_o_q    <= 1'b1;
				st_o_q     <= rmpd_pkg::ST_OK;
			end else if (run_err) begin
				sc_o_q     <= '0;
				len_o_q    <= '0;
				addr_o_q   <= '0;
				cnt_o_q    <= '0;
				sparse_o_q <= sparse_q;
				end_o_q    <= 1'b0;
				st_o_q     <= st_q;
			end else begin
				sc_o_q     <= rmpd_pkg::SC_W'(next_q);
				len_o_q    <= len_q;
				addr_o_q   <= rmpd_pkg::ADDR_W'(addr_prod_q);
				sparse_o_q <= sparse_q;
				end_o_q    <= 1'b0;
				if (st_q == rmpd_pkg::ST_CNT_OVF || cnt_over) begin
					cnt_o_q <= '1;
					st_o_q  <= rmpd_pkg::ST_CNT_OVF;
				end else begin
					cnt_o_q <= cnt_prod_q[rmpd_pkg::CNT_W-1:0];
					st_o_q  <= rmpd_pkg::ST_OK;
				end
			end
		end
	end

	assign stat.out_free   = !out_valid_q || m_tready;
	assign out_valid       = out_valid_q;
	assign start_cluster   = sc_o_q;
	assign length_clusters = len_o_q;
	assign byte_address    = addr_o_q;
	assign byte_count      = cnt_o_q;
	assign sparse_run      = sparse_o_q;
	assign list_end        = end_o_q;
	assign status          = st_o_q;

endmodule

`default_nettype wire

// ===== rtl/runlist_mapping_pair_decoder_unit.sv =====
// After the last byte of a run, the result passes the check and scale steps
// and then the output load, which waits until the output register is free.
// Throughput: one byte per cycle inside a run; each finished run holds the
// input for check, scale and output load, a zero header for the load alone.
// Reset: asynchronous; parser to header, running cluster 0, sector size 512,
// sectors per cluster 8, output empty.
// ----------------------------------------------------------------------------
// runlist_mapping_pair_decoder_unit
// Decodes a byte-wide run list into runs with cluster and byte addresses.
// ----------------------------------------------------------------------------
`default_nettype none

module runlist_mapping_pair_decoder_unit #(
	parameter int CLUSTER_BITS = rmpd_pkg::CLUSTER_BITS
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// configuration
	input  wire logic                                 cfg_we,
	input  wire logic [rmpd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [rmpd_pkg::CFG_W-1:0]           cfg_wdata,
	// byte input
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [7:0]                           s_tdata,  // run_byte
	input  wire logic                                 s_tuser,  // list_start
	// run output
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// start_cluster[39:0], length_clusters[71:40], byte_address[130:72],
	// byte_count[162:131], zero fill[167:163]
	output logic [rmpd_pkg::OUT_DATA_W-1:0]           m_tdata,
	// sparse_run[0], status[3:1]
	output logic [rmpd_pkg::OUT_USER_W-1:0]           m_tuser,
	output logic                                      m_tlast   // list_end
);

	rmpd_pkg::rmpd_cmd_t  cmd;
	rmpd_pkg::rmpd_stat_t stat;

	logic [rmpd_pkg::SC_W-1:0]   start_cluster;
	logic [rmpd_pkg::LEN_W-1:0]  length_clusters;
	logic [rmpd_pkg::ADDR_W-1:0] byte_address;
	logic [rmpd_pkg::CNT_W-1:0]  byte_count;
	logic                        sparse_run;
	logic [rmpd_pkg::ST_W-1:0]   status;

	rmpd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.run_byte   (s_tdata),
		.list_start (s_tuser),
		.stat       (stat),
		.cmd        (cmd)
	);

	rmpd_dpath #(
		.CLUSTER_BITS (CLUSTER_BITS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.run_byte        (s_tdata),
		.cmd             (cmd),
		.stat            (stat),
		.m_tready        (m_tready),
		.out_valid       (m_tvalid),
		.start_cluster   (start_cluster),
		.length_clusters (length_clusters),
		.byte_address    (byte_address),
		.byte_count      (byte_count),
		.sparse_run      (sparse_run),
		.list_end        (m_tlast),
		.status          (status)
	);

	// Pack result fields, lowest field first
	assign m_tdata = {5'd0, byte_count, byte_address, length_clusters, start_cluster};
	assign m_tuser = {status, sparse_run};

endmodule

`default_nettype wire

// ===== tb/rmpd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmpd_checker
// Watches the byte, run and configuration channels of the run list decoder.
// It keeps its own copy of the parser state, predicts every run result from
// the accepted bytes and compares each result transfer field by field.
// ----------------------------------------------------------------------------

module rmpd_checker import rmpd_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_wdata,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [7:0]            s_tdata,
	input  wire logic                  s_tuser,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [OUT_DATA_W-1:0] m_tdata,
	input  wire logic [OUT_USER_W-1:0] m_tuser,
	input  wire logic                  m_tlast,
	output int                         fail_count,
	output int                         runs_pending
);

	localparam logic [63:0] CLUSTER_MAX = (64'd1 << CLUSTER_BITS) - 64'd1;
	localparam logic [63:0] U32_MAX     = 64'hFFFF_FFFF;

	typedef enum logic [1:0] {
		P_HEADER,
		P_LENGTH,
		P_OFFSET
	} parse_t;

	typedef struct packed {
		logic [SC_W-1:0]   start_cluster;
		logic [LEN_W-1:0]  length_clusters;
		logic [ADDR_W-1:0] byte_address;
		logic [CNT_W-1:0]  byte_count;
		logic              sparse_run;
		logic              list_end;
		status_t           status;
	} run_t;

	// predictor state
	parse_t         phase;
	logic [3:0]     len_bytes;
	logic [3:0]     off_bytes;
	logic [3:0]     byte_idx;
	logic [63:0]    len_acc;
	logic [63:0]    off_acc;
	logic [63:0]    cur_cluster;
	logic [BPS_W-1:0] sector_bytes;
	logic [SPC_W-1:0] cluster_sectors;

	run_t run_q[$];
	run_t want;

	// little-endian field of n bytes, sign-extended; n = 0 reads as 0
	function automatic logic [63:0] sign_extend(logic [63:0] v, logic [3:0] n);
		int sh;
		if (n == 4'd0) return '0;
		if (n >= 4'd8) return v;
		sh = 64 - 8 * n;
		return 64'($signed(v << sh) >>> sh);
	endfunction

	// End of a run: range and size checks, cluster update, scaling
	task automatic close_run();
		logic [63:0] bpc;
		logic [63:0] len;
		logic [63:0] off;
		logic [63:0] mag;
		logic [63:0] nxt;
		logic [63:0] cnt;
		status_t     st;
		run_t        r;
		bpc = 64'(sector_bytes) * 64'(cluster_sectors);
		len = sign_extend(len_acc, len_bytes);
		off = sign_extend(off_acc, off_bytes);
		phase = P_HEADER;
		byte_idx = '0;
		r = '0;
		r.sparse_run = (off_bytes == 4'd0);
		st = ST_OK;
		nxt = '0;
		cnt = '0;
		if (len_bytes > MAX_FIELD_BYTES || off_bytes > MAX_FIELD_BYTES) begin
			st = ST_FIELD_WIDE;
		end else if (len[63]) begin
			st = ST_NEG_LEN;
		end else if (off[63]) begin
			mag = -off;
			if (mag > cur_cluster) st = ST_RANGE;
			else nxt = cur_cluster - mag;
		end else if (off > CLUSTER_MAX - cur_cluster) begin
			st = ST_RANGE;
		end else begin
			nxt = cur_cluster + off;
		end
		if (st == ST_OK) begin
			cur_cluster = nxt;
			if (len > U32_MAX) begin
				len = U32_MAX;
				cnt = U32_MAX;
				st = ST_CNT_OVF;
			end else begin
				cnt = len * bpc;
				if (cnt > U32_MAX) begin
					cnt = U32_MAX;
					st = ST_CNT_OVF;
				end
			end
			r.start_cluster   = nxt[SC_W-1:0];
			r.length_clusters = len[LEN_W-1:0];
			r.byte_address    = ADDR_W'(nxt * bpc);
			r.byte_count      = cnt[CNT_W-1:0];
		end
		r.status = st;
		run_q.push_back(r);
	endtask

	// One accepted byte through the parser
	task automatic take_byte(logic [7:0] b, logic first);
		run_t r;
		if (first) begin
			cur_cluster = '0;
			phase = P_HEADER;
		end
		case (phase)
			P_LENGTH: begin
				if (byte_idx < 4'd8) len_acc |= 64'(b) << (8 * byte_idx);
				byte_idx++;
				if (byte_idx >= len_bytes) begin
					byte_idx = '0;
					if (off_bytes > 4'd0) phase = P_OFFSET;
					else close_run();
				end
			end
			P_OFFSET: begin
				if (byte_idx < 4'd8) off_acc |= 64'(b) << (8 * byte_idx);
				byte_idx++;
				if (byte_idx >= off_bytes) close_run();
			end
			default: begin
				phase = P_HEADER;
				if (b == 8'h00) begin
					r = '0;
					r.list_end = 1'b1;
					r.status = ST_OK;
					run_q.push_back(r);
				end else begin
					len_bytes = b[3:0];
					off_bytes = b[7:4];
					byte_idx = '0;
					len_acc = '0;
					off_acc = '0;
					phase = (b[3:0] != 4'd0) ? P_LENGTH : P_OFFSET;
				end
			end
		endcase
	endtask

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
			fail_count++;
		end
	endtask

	// Compare results first, then advance the predictor with the new byte
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = P_HEADER;
			len_bytes = '0;
			off_bytes = '0;
			byte_idx = '0;
			len_acc = '0;
			off_acc = '0;
			cur_cluster = '0;
			sector_bytes = BPS_RST;
			cluster_sectors = SPC_RST;
			run_q.delete();
			fail_count = 0;
			runs_pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (run_q.size() == 0) begin
					$error("run transfer with nothing pending: tdata 0x%0h tuser 0x%0h tlast %0b",
						m_tdata, m_tuser, m_tlast);
					fail_count++;
				end else begin
					want = run_q.pop_front();
					check_field("start_cluster", 64'(want.start_cluster), 64'(m_tdata[39:0]));
					check_field("length_clusters", 64'(want.length_clusters),
						64'(m_tdata[71:40]));
					check_field("byte_address", 64'(want.byte_address), 64'(m_tdata[130:72]));
					check_field("byte_count", 64'(want.byte_count), 64'(m_tdata[162:131]));
					check_field("sparse_run", 64'(want.sparse_run), 64'(m_tuser[0]));
					check_field("list_end", 64'(want.list_end), 64'(m_tlast));
					check_field("status", 64'(want.status), 64'(m_tuser[3:1]));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_BYTES_PER_SECTOR:    sector_bytes = cfg_wdata[BPS_W-1:0];
					REG_SECTORS_PER_CLUSTER: cluster_sectors = cfg_wdata[SPC_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) take_byte(s_tdata, s_tuser);
			runs_pending <= run_q.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Byte stream stimulus for the run list decoder: a directed list of corner
// runs, then random run lists under several sector and cluster sizes, with
// random gaps on the input and random back-pressure on the output.
// ----------------------------------------------------------------------------

module tb_top;
	import rmpd_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 6;
	localparam int PHASE_BYTES  = 255;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;
	logic                  m_tlast;

	int fail_count;
	int runs_pending;
	int idle_cycles;
	int stall_left;
	int bytes_sent;
	bit steady;
	bit new_list;

	always #5 clk = ~clk;

	runlist_mapping_pair_decoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	rmpd_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast),
		.fail_count   (fail_count),
		.runs_pending (runs_pending)
	);

	// Output back-pressure: mostly short stalls, a few long ones
	always @(posedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (steady) begin
			m_tready <= 1'b1;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
		end else if (r < 60) begin
			m_tready <= 1'b1;
			stall_left = $urandom_range(0, 12);
		end else if (r < 94) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(0, 3);
		end else begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(10, 40);
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("** runlist_mapping_pair_decoder_unit: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// One byte transfer, with a random gap ahead of it
	task automatic push_byte(logic [7:0] b, logic first);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= first;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bytes_sent++;
	endtask

	// Hold the input until every pending run has been transferred
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (runs_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Bytes past the eighth carry random filler
	task automatic send_field(logic [63:0] v, logic [3:0] n);
		for (int k = 0; k < n; k++)
			push_byte((k < 8) ? v[k*8 +: 8] : 8'($urandom_range(0, 255)), 1'b0);
	endtask

	task automatic send_run(logic [3:0] lsz, logic [3:0] osz, logic [63:0] lv,
		logic [63:0] ov, logic first);
		push_byte({osz, lsz}, first);
		send_field(lv, lsz);
		send_field(ov, osz);
	endtask

	function automatic logic [3:0] size_pick();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) return 4'd0;
		if (r < 75) return 4'($urandom_range(1, 4));
		if (r < 93) return 4'($urandom_range(5, 8));
		return 4'($urandom_range(9, 15));
	endfunction

	// Mostly small values, some fully random ones
	function automatic logic [63:0] field_val(int neg_pct);
		logic [63:0] v;
		if ($urandom_range(0, 9) < 7) begin
			v = 64'($urandom_range(0, 3000));
			if ($urandom_range(0, 99) < neg_pct) v = -v;
		end else begin
			v = {$urandom, $urandom};
		end
		return v;
	endfunction

	// Random run lists: mostly well-formed runs, plus end markers,
	// runs cut short by a new list, and stray bytes
	task automatic random_phase(int nbytes);
		int         stop;
		int         r;
		logic [3:0] lsz;
		logic [3:0] osz;
		stop = bytes_sent + nbytes;
		new_list = 1'b1;
		while (bytes_sent < stop) begin
			if ($urandom_range(0, 99) < 4) steady = ~steady;
			r = $urandom_range(0, 99);
			if (r < 6) begin
				push_byte(8'h00, 1'($urandom_range(0, 1)));
			end else if (r < 10) begin
				lsz = 4'($urandom_range(1, 8));
				osz = 4'($urandom_range(1, 8));
				push_byte({osz, lsz}, new_list);
				repeat ($urandom_range(0, lsz - 1)) push_byte(8'($urandom_range(0, 255)), 1'b0);
				new_list = 1'b1;
			end else if (r < 13) begin
				push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				new_list = 1'b1;
			end else if (r < 14) begin
				wait_drained();
			end else begin
				lsz = size_pick();
				osz = size_pick();
				if (lsz == 4'd0 && osz == 4'd0) lsz = 4'd1;
				send_run(lsz, osz, field_val(5), field_val(30),
					new_list || ($urandom_range(0, 99) < 8));
				new_list = 1'b0;
			end
		end
	endtask

	initial begin
		logic [BPS_W-1:0] bps_set[5];
		logic [SPC_W-1:0] spc_set[5];
		bps_set = '{13'd512, 13'd1024, 13'd2048, 13'd4096, 13'd512};
		spc_set = '{8'd1, 8'd64, 8'd8, 8'd1, 8'd128};
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = REG_BYTES_PER_SECTOR;
		cfg_wdata  = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = 1'b0;
		m_tready   = 1'b0;
		steady     = 1'b0;
		new_list   = 1'b1;
		stall_left = 0;
		bytes_sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corner runs at the reset geometry
		// cluster at the top of the range, then one step past it
		send_run(4'd1, 4'd6, 64'h01, 64'h00FF_FFFF_FFFF, 1'b1);
		send_run(4'd1, 4'd1, 64'h01, 64'h01, 1'b0);
		// negative length wins over a valid offset
		send_run(4'd1, 4'd1, 64'h80, 64'hF0, 1'b0);
		// no length bytes
		send_run(4'd0, 4'd1, 64'h0, 64'h05, 1'b1);
		// negative offset below cluster zero
		send_run(4'd1, 4'd1, 64'h02, 64'hF8, 1'b0);
		// sparse run whose byte count overflows 32 bits
		send_run(4'd3, 4'd0, 64'h40_0000, 64'h0, 1'b0);
		// length field of nine bytes
		send_run(4'd9, 4'd0, {$urandom, $urandom}, 64'h0, 1'b0);
		// run cut short by a new list that is just an end marker
		push_byte(8'h22, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'h00, 1'b1);

		// largest geometry first, then the rest
		write_reg(REG_BYTES_PER_SECTOR, CFG_W'(4096));
		write_reg(REG_SECTORS_PER_CLUSTER, CFG_W'(128));
		random_phase(PHASE_BYTES);
		for (int p = 0; p < 5; p++) begin
			write_reg(REG_BYTES_PER_SECTOR, CFG_W'(bps_set[p]));
			write_reg(REG_SECTORS_PER_CLUSTER, CFG_W'(spc_set[p]));
			random_phase(PHASE_BYTES);
		end

		wait_drained();
		if (fail_count == 0 && runs_pending == 0)
			$display("** runlist_mapping_pair_decoder_unit: PASSED **");
		else
			$display("** runlist_mapping_pair_decoder_unit: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/rmpd_pkg.sv
rtl/rmpd_ctrl.sv
rtl/rmpd_dpath.sv
rtl/runlist_mapping_pair_decoder_unit.sv
tb/rmpd_checker.sv
tb/tb_top.sv
